// ===== rtl/core/fcrng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrng_pkg: shared types and constants of the rotate-add RNG core
// Word width, seed constants and command codes.
// ----------------------------------------------------------------------------
package fcrng_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;    // counts 32 seed steps / 32 divide bits

    localparam logic [WORD_W-1:0] ZERO_SEED_SUBST = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] SEED_XOR        = 32'hbead29ba;
    localparam logic [15:0]       MAX_PICK_COUNT  = 16'hffff;

    typedef enum logic [1:0] {
        CMD_SEED   = 2'd0,
        CMD_RANDOM = 2'd1,
        CMD_PICK   = 2'd2
    } cmd_t;

endpackage

// ===== rtl/core/fcrng_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrng_div: bit-serial restoring remainder unit
// One dividend bit enters the partial remainder per cycle while a run is active.
// ----------------------------------------------------------------------------
module fcrng_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fcrng_pkg::WORD_W-1:0]  dividend,
    input  logic [fcrng_pkg::WORD_W-1:0]  divisor,
    output logic                          done,
    output logic [fcrng_pkg::WORD_W-1:0]  remainder
);
    import fcrng_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    shf_reg, shf_next;
    logic [WORD_W-1:0]    dvs_reg, dvs_next;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;

    // trial < 2*divisor, so the restored value always fits in a word
    assign trial = {rem_reg, shf_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            shf_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
            shf_next = {shf_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/fantasy_console_rng_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fantasy_console_rng_core: rotate-add pseudo-random generator
// Seed, random-below-range and pick-index commands over two 32-bit words.
// ----------------------------------------------------------------------------
//
//   channel   | signals                    | handshake
//   ----------+----------------------------+-----------------------------------
//   request   | command, operand           | taken when start & !busy
//   result    | value, is_empty            | valid for one cycle while strobe
//
// Seed: 32 generator steps, one per cycle, no result.
// Random / pick: one generator step, then the bit-serial remainder unit
//   divides the stepped word; the result is strobed once it is done. A range or count
//   that is zero or negative skips the divider: result strobed from the step state.
// Command 3 is dropped; busy stays low.
// Reset runs the zero-seed sequence: busy is high while its seed steps run after
//   rst_n rises. The result side cannot stall; strobe is a single-cycle pulse.
// ----------------------------------------------------------------------------
module fantasy_console_rng_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [1:0]                         command,
    input  logic signed [fcrng_pkg::WORD_W-1:0] operand,
    output logic                               busy,
    output logic                               strobe,
    output logic [30:0]                        value,
    output logic                               is_empty
);
    import fcrng_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_STEP,
        ST_DIV
    } state_t;

    state_t               state_reg, state_next;
    logic [WORD_W-1:0]    a_reg, a_next;
    logic [WORD_W-1:0]    b_reg, b_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [WORD_W-1:0]    opnd_reg, opnd_next;
    logic                 strobe_reg, strobe_next;
    logic [30:0]          value_reg, value_next;
    logic                 empty_reg, empty_next;

    logic [WORD_W-1:0]    b_swap;
    logic [WORD_W-1:0]    a_step;
    logic [WORD_W-1:0]    b_step;
    logic [WORD_W-1:0]    seed_a;
    logic                 opnd_bad;
    logic [15:0]          count_sat;
    logic [WORD_W-1:0]    divisor;
    logic                 div_start;
    logic                 div_done;
    logic [WORD_W-1:0]    div_rem;
    logic [16:0]          pick_idx;

    // one step: b' = a + swap(b); a' = a + b' = 2a + swap(b), two parallel adds
    assign b_swap = {b_reg[15:0], b_reg[31:16]};
    assign b_step = a_reg + b_swap;
    assign a_step = {a_reg[WORD_W-2:0], 1'b0} + b_swap;

    assign seed_a = (operand == '0) ? ZERO_SEED_SUBST : WORD_W'(operand);

    // zero or negative range / count: no division
    assign opnd_bad  = opnd_reg[WORD_W-1] || (opnd_reg == '0);
    assign count_sat = (|opnd_reg[30:16]) ? MAX_PICK_COUNT : opnd_reg[15:0];
    assign divisor   = (cmd_reg == CMD_PICK) ? {count_sat, 16'h0000} : opnd_reg;
    assign div_start = (state_reg == ST_STEP) && !opnd_bad;
    assign pick_idx  = {1'b0, div_rem[31:16]} + 17'd1;

    fcrng_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (b_step),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        opnd_next   = opnd_reg;
        strobe_next = 1'b0;
        value_next  = value_reg;
        empty_next  = empty_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd_t'(command);
                    opnd_next = WORD_W'(operand);
                    case (command) inside
                        CMD_SEED:
                        begin
                            a_next     = seed_a;
                            b_next     = seed_a ^ SEED_XOR;
                            cnt_next   = '0;
                            state_next = ST_SEED;
                        end
                        CMD_RANDOM, CMD_PICK:
                        begin
                            state_next = ST_STEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED:
            begin
                a_next   = a_step;
                b_next   = b_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                a_next = a_step;
                b_next = b_step;
                if (opnd_bad)
                begin
                    strobe_next = 1'b1;
                    value_next  = '0;
                    empty_next  = (cmd_reg == CMD_PICK);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    strobe_next = 1'b1;
                    empty_next  = 1'b0;
                    value_next  = (cmd_reg == CMD_PICK) ? 31'(pick_idx) : div_rem[30:0];
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset loads the zero-seed words and runs the seed steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SEED;
            a_reg      <= ZERO_SEED_SUBST;
            b_reg      <= ZERO_SEED_SUBST ^ SEED_XOR;
            cnt_reg    <= '0;
            cmd_reg    <= CMD_SEED;
            opnd_reg   <= '0;
            strobe_reg <= 1'b0;
            value_reg  <= '0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            cnt_reg    <= cnt_next;
            cmd_reg    <= cmd_next;
            opnd_reg   <= opnd_next;
            strobe_reg <= strobe_next;
            value_reg  <= value_next;
            empty_reg  <= empty_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign strobe   = strobe_reg;
    assign value    = value_reg;
    assign is_empty = empty_reg;

`ifndef SYNTHESIS
    // results only appear once the core has returned to idle
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result strobed while busy");

    // an empty pick always carries a zero value
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_empty) |-> (value == '0))
        else $error("empty flag without zero value");

    // every request passes through the step state before its result, so strobes never abut
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("back-to-back strobes");

    // a seed request keeps the core busy and yields no result
    a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_SEED) |=> (busy && !strobe))
        else $error("seed request did not start");
`endif

endmodule
